// File: src/sacc_pkg.sv
// shared types and constants of the set-associative cache controller
package sacc_pkg;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 32;

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int SET_BITS  = $clog2(SETS);
    localparam int BLK_BITS  = ADDR_BITS - OFF_BITS;
    localparam int TAG_BITS  = BLK_BITS - SET_BITS;
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int RANK_BITS = $clog2(WAYS + 1);
    localparam int OUT_BITS  = 2 * ADDR_BITS + WAY_BITS + 6;

    typedef enum logic [1:0] {
        REQ_READ      = 2'd0,
        REQ_WRITE     = 2'd1,
        REQ_CHILD_MOD = 2'd2,
        REQ_BACK_INV  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_INV = 2'd0,
        ST_SHR = 2'd1,
        ST_MOD = 2'd2,
        ST_MAB = 2'd3
    } line_state_t;

    // configuration register index, byte address is four times this
    typedef enum logic [1:0] {
        REG_WB_MODE = 2'd0,
        REG_UPPER   = 2'd1,
        REG_LOWER   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic write_back_mode;
        logic has_upper_caches;
        logic has_lower_cache;
    } cfg_t;

    // one set: tags, line states and recency ranks of all ways
    typedef struct packed {
        logic [WAYS-1:0][TAG_BITS-1:0]  tag;
        logic [WAYS-1:0][1:0]           st;
        logic [WAYS-1:0][RANK_BITS-1:0] rank;
    } set_row_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] line_addr;
        logic                 invalidate_upper;
        logic                 notify_lower_modified;
        logic [ADDR_BITS-1:0] victim_addr;
        logic                 writeback_victim;
        logic                 write_through;
        logic                 fetch_block;
        logic [WAY_BITS-1:0]  way;
        logic                 hit;
    } resp_t;

endpackage

// File: src/set_assoc_cache_controller_top.sv
// top level of the set-associative cache tag and state controller
//
//  channel   direction  payload
//  s_axis    in         tuser: req_type; tdata: address
//  m_axis    out        tdata: hit .. line_addr, one result per request
//  apb       in/out     write_back_mode, has_upper_caches, has_lower_cache
//
// one request per cycle while m_axis is not stalled; the set ram is read on the
// edge that accepts a request; the lookup result and set write happen on advance
// a request to the set just written takes the new row from a bypass register
// per-set valid bits are cleared by reset, so no clearing pass is needed
// a stalled m_axis holds the lookup stage and back-pressures s_axis
module set_assoc_cache_controller_top import sacc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] address
    input  logic [1:0]           s_axis_tuser,   // [1:0] req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] hit, [2:1] way, [3] fetch_block, [4] write_through,
    // [5] writeback_victim, [37:6] victim_addr, [38] notify_lower_modified,
    // [39] invalidate_upper, [71:40] line_addr
    output logic [OUT_BITS-1:0]  m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t                cfg;
    logic                s1_valid_reg;
    req_t                s1_req_reg;
    logic [BLK_BITS-1:0] s1_blk_reg;
    logic                fwd_valid_reg;
    set_row_t            fwd_row_reg;
    logic [SETS-1:0]     row_valid_reg;
    logic                m_valid_reg;
    resp_t               m_data_reg;

    logic                accept;
    logic                adv;
    logic [SET_BITS-1:0] in_set;
    logic [SET_BITS-1:0] s1_set;
    set_row_t            ram_row;
    set_row_t            cur_row;
    set_row_t            new_row;
    resp_t               resp;

    sacc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_set        = s_axis_tdata[OFF_BITS +: SET_BITS];
    assign s1_set        = s1_blk_reg[SET_BITS-1:0];
    assign adv           = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sacc_ram #(
        .WIDTH ($bits(set_row_t)),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (s1_set),
        .wr_data (new_row),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (ram_row)
    );

    // unwritten sets read as all invalid with zero ranks
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            cur_row = fwd_row_reg;
        end
        else
        begin
            cur_row = ram_row;
            if (!row_valid_reg[s1_set])
            begin
                cur_row.st   = '0;
                cur_row.rank = '0;
            end
        end
    end

    sacc_update u_update (
        .req     (s1_req_reg),
        .blk     (s1_blk_reg),
        .row_in  (cur_row),
        .cfg     (cfg),
        .row_out (new_row),
        .resp    (resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= adv && (s1_set == in_set);
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                row_valid_reg[s1_set] <= 1'b1;
                m_valid_reg           <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req_t'(s_axis_tuser);
            s1_blk_reg  <= s_axis_tdata[ADDR_BITS-1:OFF_BITS];
            fwd_row_reg <= new_row;
        end
        if (adv)
        begin
            m_data_reg <= resp;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_hit_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg.hit && m_data_reg.fetch_block))
        else $error("hit result also requests a fetch");

    a_victim_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && (m_data_reg.writeback_victim || m_data_reg.invalidate_upper)
        |-> m_data_reg.fetch_block)
        else $error("eviction reported without a fill");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_blk_reg))
        else $error("lookup stage lost its request while stalled");

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_valid_reg)
        else $error("completed lookup produced no result");

endmodule

// File: src/sacc_ram.sv
// generic single-write, single-read ram with registered read data
module sacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sacc_cfg.sv
// configuration registers behind the apb port
module sacc_cfg import sacc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_fire;

    assign pready  = 1'b1;
    assign idx     = reg_idx_t'(paddr[3:2]);
    assign wr_fire = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_back_mode  <= 1'b1;
            cfg_reg.has_upper_caches <= 1'b0;
            cfg_reg.has_lower_cache  <= 1'b1;
        end
        else if (wr_fire)
        begin
            case (idx)
                REG_WB_MODE: cfg_reg.write_back_mode  <= pwdata[0];
                REG_UPPER:   cfg_reg.has_upper_caches <= pwdata[0];
                REG_LOWER:   cfg_reg.has_lower_cache  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WB_MODE: prdata = {31'd0, cfg_reg.write_back_mode};
            REG_UPPER:   prdata = {31'd0, cfg_reg.has_upper_caches};
            REG_LOWER:   prdata = {31'd0, cfg_reg.has_lower_cache};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// File: src/sacc_update.sv
// lookup, victim choice and next state of one set for one request
module sacc_update import sacc_pkg::*; (
    input  req_t                 req,
    input  logic [BLK_BITS-1:0]  blk,
    input  set_row_t             row_in,
    input  cfg_t                 cfg,
    output set_row_t             row_out,
    output resp_t                resp
);

    // touched way newest; newer valid ways age (all on a miss), saturating
    function automatic logic [WAYS-1:0][RANK_BITS-1:0] touch(
        input logic [WAYS-1:0][RANK_BITS-1:0] rk,
        input logic [WAYS-1:0][1:0]           st,
        input logic [WAY_BITS-1:0]            w,
        input logic                           on_hit
    );
        logic [WAYS-1:0][RANK_BITS-1:0] res;
        res = rk;
        for (int j = 0; j < WAYS; j++)
        begin
            if (WAY_BITS'(j) != w && st[j] != ST_INV && (!on_hit || rk[j] < rk[w])
                && rk[j] < RANK_BITS'(WAYS))
            begin
                res[j] = rk[j] + RANK_BITS'(1);
            end
        end
        res[w] = RANK_BITS'(1);
        return res;
    endfunction

    logic [SET_BITS-1:0]  set_idx;
    logic [TAG_BITS-1:0]  tag;
    logic                 found;
    logic                 has_free;
    logic [WAY_BITS-1:0]  hw;
    logic [WAY_BITS-1:0]  fw;
    logic [WAY_BITS-1:0]  vw;
    logic [WAY_BITS-1:0]  tw;
    logic [RANK_BITS-1:0] best;

    assign set_idx = blk[SET_BITS-1:0];
    assign tag     = blk[BLK_BITS-1:SET_BITS];

    always_comb
    begin
        found    = 1'b0;
        has_free = 1'b0;
        hw       = '0;
        fw       = '0;
        vw       = '0;
        best     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            // first matching valid way wins
            if (!found && row_in.st[w] != ST_INV && row_in.tag[w] == tag)
            begin
                found = 1'b1;
                hw    = WAY_BITS'(w);
            end
            if (row_in.st[w] == ST_INV)
            begin
                has_free = 1'b1;
                fw       = WAY_BITS'(w);
            end
            // oldest rank, ties to the higher way
            if (row_in.rank[w] >= best)
            begin
                best = row_in.rank[w];
                vw   = WAY_BITS'(w);
            end
        end
    end

    assign tw = has_free ? fw : vw;

    always_comb
    begin
        row_out        = row_in;
        resp           = '0;
        resp.line_addr = {blk, {OFF_BITS{1'b0}}};
        if (found)
        begin
            resp.hit = 1'b1;
            resp.way = hw;
            case (req)
                REQ_READ:
                begin
                    row_out.rank = touch(row_in.rank, row_in.st, hw, 1'b1);
                end
                REQ_WRITE:
                begin
                    row_out.rank = touch(row_in.rank, row_in.st, hw, 1'b1);
                    if (cfg.write_back_mode)
                    begin
                        if (row_in.st[hw] == ST_SHR)
                        begin
                            row_out.st[hw]             = ST_MOD;
                            resp.notify_lower_modified = cfg.has_lower_cache;
                        end
                    end
                    else
                    begin
                        resp.write_through = 1'b1;
                    end
                end
                REQ_CHILD_MOD:
                begin
                    if (row_in.st[hw] == ST_MOD || row_in.st[hw] == ST_SHR)
                    begin
                        row_out.st[hw]             = ST_MAB;
                        resp.notify_lower_modified = cfg.has_lower_cache;
                    end
                end
                REQ_BACK_INV:
                begin
                    if (row_in.st[hw] == ST_SHR || row_in.st[hw] == ST_MAB)
                    begin
                        row_out.st[hw]   = ST_INV;
                        row_out.rank[hw] = '0;
                    end
                end
                default: ;
            endcase
        end
        else if (req == REQ_READ || req == REQ_WRITE)
        begin
            if (!has_free)
            begin
                resp.invalidate_upper = cfg.has_upper_caches;
                resp.writeback_victim = (row_in.st[vw] == ST_MOD);
                resp.victim_addr      = {row_in.tag[vw], set_idx, {OFF_BITS{1'b0}}};
            end
            resp.way         = tw;
            resp.fetch_block = 1'b1;
            row_out.tag[tw]  = tag;
            if (req == REQ_WRITE && cfg.write_back_mode)
            begin
                row_out.st[tw]             = ST_MOD;
                resp.notify_lower_modified = cfg.has_lower_cache;
            end
            else
            begin
                row_out.st[tw]     = ST_SHR;
                resp.write_through = (req == REQ_WRITE);
            end
            row_out.rank = touch(row_in.rank, row_in.st, tw, 1'b0);
        end
    end

endmodule
